>>> design/sdtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtp_pkg
// shared types and constants for the service description section parser
// ----------------------------------------------------------------------------
package sdtp_pkg;

   localparam int BYTE_W      = 8;
   localparam int TAG_W       = 5;
   localparam int VALUE_W     = 32;
   localparam int SVC_W       = 10;
   localparam int POS_W       = 13;
   localparam int DESC_W      = 12;
   localparam int MAX_RESULTS = 3;

   localparam logic [SVC_W-1:0] MAX_SERVICES = 10'd1023;

   // result queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = 3;
   localparam int QUEUE_CNT_W = 4;

   // field tags
   localparam logic [TAG_W-1:0] TAG_TABLE_ID       = 5'd0;
   localparam logic [TAG_W-1:0] TAG_SYNTAX_IND     = 5'd1;
   localparam logic [TAG_W-1:0] TAG_HDR_RFU        = 5'd2;
   localparam logic [TAG_W-1:0] TAG_HDR_RESERVED   = 5'd3;
   localparam logic [TAG_W-1:0] TAG_SEC_LEN        = 5'd4;
   localparam logic [TAG_W-1:0] TAG_TS_ID          = 5'd5;
   localparam logic [TAG_W-1:0] TAG_VER_RESERVED   = 5'd6;
   localparam logic [TAG_W-1:0] TAG_VERSION        = 5'd7;
   localparam logic [TAG_W-1:0] TAG_CURRENT_NEXT   = 5'd8;
   localparam logic [TAG_W-1:0] TAG_SECTION_NUM    = 5'd9;
   localparam logic [TAG_W-1:0] TAG_LAST_SECTION   = 5'd10;
   localparam logic [TAG_W-1:0] TAG_ORIG_NET_ID    = 5'd11;
   localparam logic [TAG_W-1:0] TAG_NET_RFU        = 5'd12;
   localparam logic [TAG_W-1:0] TAG_SERVICE_ID     = 5'd13;
   localparam logic [TAG_W-1:0] TAG_SVC_RFU        = 5'd14;
   localparam logic [TAG_W-1:0] TAG_EIT_SCHEDULE   = 5'd15;
   localparam logic [TAG_W-1:0] TAG_EIT_PF         = 5'd16;
   localparam logic [TAG_W-1:0] TAG_RUNNING_STATUS = 5'd17;
   localparam logic [TAG_W-1:0] TAG_FREE_CA        = 5'd18;
   localparam logic [TAG_W-1:0] TAG_DESC_LOOP_LEN  = 5'd19;
   localparam logic [TAG_W-1:0] TAG_DESC_BYTE      = 5'd20;
   localparam logic [TAG_W-1:0] TAG_CRC            = 5'd21;
   localparam logic [TAG_W-1:0] TAG_SVC_COUNT      = 5'd22;
   localparam logic [TAG_W-1:0] TAG_MALFORMED      = 5'd23;

   typedef struct packed {
      logic [TAG_W-1:0]   field_tag;
      logic [VALUE_W-1:0] field_value;
      logic [SVC_W-1:0]   service_number;
      logic               last_of_run;
      logic               section_done;
   } result_type;

   // results caused by one request
   typedef struct packed {
      logic [1:0]                        count;
      result_type [MAX_RESULTS-1:0]      slot;
   } group_type;

endpackage

>>> design/sdtp_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtp channels
// valid/ready request and result channels of the section parser
// ----------------------------------------------------------------------------
interface sdtp_req_if
   import sdtp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] section_byte;
   logic              first_of_section;

   modport source (output valid, output section_byte, output first_of_section, input ready);
   modport sink   (input valid, input section_byte, input first_of_section, output ready);
endinterface

interface sdtp_rsp_if
   import sdtp_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [TAG_W-1:0]   field_tag;
   logic [VALUE_W-1:0] field_value;
   logic [SVC_W-1:0]   service_number;
   logic               last_of_run;
   logic               section_done;

   modport source (output valid, output field_tag, output field_value,
                   output service_number, output last_of_run, output section_done,
                   input ready);
   modport sink   (input valid, input field_tag, input field_value,
                   input service_number, input last_of_run, input section_done,
                   output ready);
endinterface

>>> design/sdt_section_field_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_section_field_parser_top
// parses section bytes into tagged fields and queues them for the result side
// ----------------------------------------------------------------------------
// a request's results are registered into the queue as the request is accepted
// throughput: one request a cycle, one result a cycle out of an 8-entry queue;
//   a byte that yields more than one result offers them on the result port in slot order
// requests stall while the queue has fewer than three free entries
// reset clears the section state and empties the queue
module sdt_section_field_parser_top
   import sdtp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   sdtp_req_if.sink   req_chan,
   sdtp_rsp_if.source rsp_chan
);

   group_type                     group;
   logic                          req_take;
   logic                          rsp_take;
   result_type [QUEUE_DEPTH-1:0]  queue_ff;
   logic [QUEUE_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]        fill_ff, fill_in;
   logic [1:0]                    push_n;
   result_type                    head;

   assign req_chan.ready = (fill_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
   assign req_take       = req_chan.valid & req_chan.ready;
   assign rsp_take       = rsp_chan.valid & rsp_chan.ready;

   sdtp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_take),
      .section_byte     (req_chan.section_byte),
      .first_of_section (req_chan.first_of_section),
      .group            (group)
   );

   assign push_n    = req_take ? group.count : 2'd0;
   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(rsp_take);
   assign fill_in   = fill_ff + QUEUE_CNT_W'(push_n) - QUEUE_CNT_W'(rsp_take);

   assign head                    = queue_ff[rd_ptr_ff];
   assign rsp_chan.valid          = (fill_ff != '0);
   assign rsp_chan.field_tag      = head.field_tag;
   assign rsp_chan.field_value    = head.field_value;
   assign rsp_chan.service_number = head.service_number;
   assign rsp_chan.last_of_run    = head.last_of_run;
   assign rsp_chan.section_done   = head.section_done;

   // each entry takes the group slot that lands on it
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         logic [QUEUE_PTR_W-1:0] offset;
         offset = QUEUE_PTR_W'(i) - wr_ptr_ff;
         if (offset < QUEUE_PTR_W'(push_n)) begin
            queue_ff[i] <= group.slot[offset[1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> design/sdtp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtp_parser
// section state and per-byte field extraction, up to three results a byte
// ----------------------------------------------------------------------------
module sdtp_parser
   import sdtp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] section_byte,
   input  logic              first_of_section,
   output group_type         group
);

   typedef enum logic [2:0] {
      PH_SID_HI   = 3'd0,
      PH_SID_LO   = 3'd1,
      PH_FLAGS    = 3'd2,
      PH_STATUS   = 3'd3,
      PH_LOOP_LEN = 3'd4,
      PH_DISCARD  = 3'd7
   } phase_type;

   localparam logic [POS_W-1:0] POS_TABLE_ID     = 13'd0;
   localparam logic [POS_W-1:0] POS_SYNTAX       = 13'd1;
   localparam logic [POS_W-1:0] POS_LENGTH       = 13'd2;
   localparam logic [POS_W-1:0] POS_TSID_HI      = 13'd3;
   localparam logic [POS_W-1:0] POS_TSID_LO      = 13'd4;
   localparam logic [POS_W-1:0] POS_VERSION      = 13'd5;
   localparam logic [POS_W-1:0] POS_SECTION_NUM  = 13'd6;
   localparam logic [POS_W-1:0] POS_LAST_SECTION = 13'd7;
   localparam logic [POS_W-1:0] POS_ONID_HI      = 13'd8;
   localparam logic [POS_W-1:0] POS_ONID_LO      = 13'd9;
   localparam logic [POS_W-1:0] HEADER_BYTES     = 13'd11;
   localparam logic [DESC_W-1:0] MIN_LENGTH      = 12'd12;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   total_ff, total_in;
   phase_type          phase_ff, phase_in;
   logic [DESC_W-1:0]  desc_left_ff, desc_left_in;
   logic [SVC_W-1:0]   svc_count_ff, svc_count_in;
   logic [VALUE_W-1:0] partial_ff, partial_in;
   logic               active_ff, active_in;

   logic [POS_W-1:0]   pos;
   logic [POS_W-1:0]   total;
   phase_type          phase;
   logic [DESC_W-1:0]  desc_left;
   logic [SVC_W-1:0]   svc_count;
   logic [VALUE_W-1:0] partial;
   logic               active;

   logic [POS_W-1:0]   crc_start;
   logic [DESC_W-1:0]  len_hdr;
   logic [DESC_W-1:0]  len_svc;
   logic [SVC_W-1:0]   cur_idx;
   logic               done;
   logic [7:0]         b;

   function automatic result_type mk(input logic [TAG_W-1:0] tag,
                                     input logic [VALUE_W-1:0] value,
                                     input logic [SVC_W-1:0] svc);
      result_type r;
      r.field_tag      = tag;
      r.field_value    = value;
      r.service_number = svc;
      r.last_of_run    = 1'b0;
      r.section_done   = 1'b0;
      return r;
   endfunction

   always_comb begin
      b = section_byte;
      // a start byte clears the section state before it is parsed
      pos       = first_of_section ? '0 : pos_ff;
      total     = first_of_section ? '0 : total_ff;
      phase     = first_of_section ? PH_SID_HI : phase_ff;
      desc_left = first_of_section ? '0 : desc_left_ff;
      svc_count = first_of_section ? '0 : svc_count_ff;
      partial   = first_of_section ? '0 : partial_ff;
      active    = first_of_section | active_ff;

      pos_in       = pos;
      total_in     = total;
      phase_in     = phase;
      desc_left_in = desc_left;
      svc_count_in = svc_count;
      partial_in   = partial;
      active_in    = active;

      crc_start = total - 13'd4;
      len_hdr   = {partial[3:0], b};
      len_svc   = {partial[3:0], b};
      cur_idx   = (svc_count != '0) ? svc_count - 10'd1 : '0;
      done      = 1'b0;
      group     = '0;

      if (active) begin
         if (pos < HEADER_BYTES) begin
            unique case (pos)
               POS_TABLE_ID: begin
                  group.slot[0] = mk(TAG_TABLE_ID, {24'd0, b}, '0);
                  group.count   = 2'd1;
               end
               POS_SYNTAX: begin
                  group.slot[0] = mk(TAG_SYNTAX_IND, {31'd0, b[7]}, '0);
                  group.slot[1] = mk(TAG_HDR_RFU, {31'd0, b[6]}, '0);
                  group.slot[2] = mk(TAG_HDR_RESERVED, {30'd0, b[5:4]}, '0);
                  group.count   = 2'd3;
                  partial_in    = {24'd0, b};
               end
               POS_LENGTH: begin
                  total_in      = 13'd3 + {1'b0, len_hdr};
                  group.slot[0] = mk(TAG_SEC_LEN, {20'd0, len_hdr}, '0);
                  group.count   = 2'd1;
                  if (len_hdr < MIN_LENGTH) begin
                     group.slot[1] = mk(TAG_MALFORMED, {20'd0, len_hdr}, '0);
                     group.count   = 2'd2;
                     done          = 1'b1;
                     active_in     = 1'b0;
                  end
               end
               POS_TSID_HI: partial_in = {24'd0, b};
               POS_TSID_LO: begin
                  group.slot[0] = mk(TAG_TS_ID, {16'd0, partial[7:0], b}, '0);
                  group.count   = 2'd1;
               end
               POS_VERSION: begin
                  group.slot[0] = mk(TAG_VER_RESERVED, {30'd0, b[7:6]}, '0);
                  group.slot[1] = mk(TAG_VERSION, {27'd0, b[5:1]}, '0);
                  group.slot[2] = mk(TAG_CURRENT_NEXT, {31'd0, b[0]}, '0);
                  group.count   = 2'd3;
               end
               POS_SECTION_NUM: begin
                  group.slot[0] = mk(TAG_SECTION_NUM, {24'd0, b}, '0);
                  group.count   = 2'd1;
               end
               POS_LAST_SECTION: begin
                  group.slot[0] = mk(TAG_LAST_SECTION, {24'd0, b}, '0);
                  group.count   = 2'd1;
               end
               POS_ONID_HI: partial_in = {24'd0, b};
               POS_ONID_LO: begin
                  group.slot[0] = mk(TAG_ORIG_NET_ID, {16'd0, partial[7:0], b}, '0);
                  group.count   = 2'd1;
               end
               default: begin
                  group.slot[0] = mk(TAG_NET_RFU, {24'd0, b}, '0);
                  group.count   = 2'd1;
                  phase_in      = PH_SID_HI;
                  desc_left_in  = '0;
               end
            endcase
         end else if (pos >= crc_start) begin
            partial_in = {partial[23:0], b};
            if ({1'b0, pos} + 14'd1 >= {1'b0, total}) begin
               group.slot[0] = mk(TAG_CRC, {partial[23:0], b}, '0);
               group.slot[1] = mk(TAG_SVC_COUNT, {22'd0, svc_count}, '0);
               group.count   = 2'd2;
               done          = 1'b1;
               active_in     = 1'b0;
            end
         end else if (phase == PH_DISCARD) begin
            // cut-off service, skip up to the crc
         end else if (desc_left != '0) begin
            group.slot[0] = mk(TAG_DESC_BYTE, {24'd0, b}, cur_idx);
            group.count   = 2'd1;
            desc_left_in  = desc_left - 12'd1;
         end else begin
            unique case (phase)
               PH_SID_HI: begin
                  if (crc_start - pos < 13'd5) begin
                     phase_in = PH_DISCARD;
                  end else begin
                     if (svc_count < MAX_SERVICES) svc_count_in = svc_count + 10'd1;
                     partial_in = {24'd0, b};
                     phase_in   = PH_SID_LO;
                  end
               end
               PH_SID_LO: begin
                  group.slot[0] = mk(TAG_SERVICE_ID, {16'd0, partial[7:0], b}, cur_idx);
                  group.count   = 2'd1;
                  phase_in      = PH_FLAGS;
               end
               PH_FLAGS: begin
                  group.slot[0] = mk(TAG_SVC_RFU, {26'd0, b[7:2]}, cur_idx);
                  group.slot[1] = mk(TAG_EIT_SCHEDULE, {31'd0, b[1]}, cur_idx);
                  group.slot[2] = mk(TAG_EIT_PF, {31'd0, b[0]}, cur_idx);
                  group.count   = 2'd3;
                  phase_in      = PH_STATUS;
               end
               PH_STATUS: begin
                  group.slot[0] = mk(TAG_RUNNING_STATUS, {29'd0, b[7:5]}, cur_idx);
                  group.slot[1] = mk(TAG_FREE_CA, {31'd0, b[4]}, cur_idx);
                  group.count   = 2'd2;
                  partial_in    = {24'd0, b};
                  phase_in      = PH_LOOP_LEN;
               end
               default: begin
                  group.slot[0] = mk(TAG_DESC_LOOP_LEN, {20'd0, len_svc}, cur_idx);
                  group.count   = 2'd1;
                  desc_left_in  = len_svc;
                  phase_in      = PH_SID_HI;
               end
            endcase
         end

         pos_in = active_in ? pos + 13'd1 : '0;
      end

      for (int k = 0; k < MAX_RESULTS; k++) begin
         group.slot[k].last_of_run  = (2'(k) + 2'd1 == group.count);
         group.slot[k].section_done = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         total_ff     <= '0;
         phase_ff     <= PH_SID_HI;
         desc_left_ff <= '0;
         svc_count_ff <= '0;
         partial_ff   <= '0;
         active_ff    <= 1'b0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         phase_ff     <= phase_in;
         desc_left_ff <= desc_left_in;
         svc_count_ff <= svc_count_in;
         partial_ff   <= partial_in;
         active_ff    <= active_in;
      end
   end

endmodule
